@@ rtl/joystick_packet_deframer_filter_unit_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the joystick deframer blocks.
// ------------------------------------------------------------------------
`ifndef JOYSTICK_PACKET_DEFRAMER_FILTER_UNIT_MACROS_SVH
`define JOYSTICK_PACKET_DEFRAMER_FILTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define JPDF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpdf assertion failed");

// next-cycle implication
`define JPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpdf assertion failed");

`else

`define JPDF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define JPDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/jpdf_pkg.sv @@
// ------------------------------------------------------------------------
// jpdf_pkg
// Types and constants shared by the joystick packet deframer and filter.
// ------------------------------------------------------------------------
package jpdf_pkg;

  localparam int FILTER_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS   = 16;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int PKT_BYTES  = 6;
  localparam int POS_W      = 3;
  localparam int DZ_W       = 15;
  localparam int GAIN_W     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int FV_W       = 40;
  localparam int TS_W       = 24;
  localparam int TURN_W     = 17;

  localparam int XW     = WORD_W + FILTER_FRAC_BITS;
  localparam int DIFF_W = WORD_W + FILTER_FRAC_BITS + 2;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int Q8_SH  = FILTER_FRAC_BITS - 8;
  localparam int NEG_W  = FV_W + 1;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PKT_BYTES);
  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(PKT_BYTES + 1);

  localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hA5;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h5A;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(9830);
  localparam logic [DZ_W-1:0]   DZ_RESET   = DZ_W'(5);

  localparam logic signed [NEG_W-1:0] TS_MAX = NEG_W'(8388607);
  localparam logic signed [NEG_W-1:0] TS_MIN = -NEG_W'(8388608);

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 1'd1;

  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] turn;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_OUT
  } back_state_e;

endpackage

@@ rtl/joystick_packet_deframer_filter_unit.sv @@
// ------------------------------------------------------------------------
// joystick_packet_deframer_filter_unit
// Deframes 7-byte joystick packets and low-pass filters the speed.
// ------------------------------------------------------------------------
// Input channel: one packet byte per item (rx_byte_i) with packet_start_i
// marking byte 0. Bytes are taken at one per cycle; in_stall_o rises only
// when the two-entry job queue is full, which needs the output side to be
// stalled for several packets.
// Output channel: one item per seventh byte, carrying accepted_o, the
// negated filtered speed (Q8, saturated) and the negated turn. A rejected
// packet repeats the last speed and turn with accepted_o low.
// Result path: the job goes through the queue; the filter sequencer pops it,
// multiplies, accumulates and loads the output register, finishing a packet
// before the next has fully arrived unless out_stall_i holds it.
// While out_stall_i is high and out_valid_o is set, the result register holds
// and the sequencer waits in its output step; bytes keep going into the queue.
// Reset clears the byte position, filter value, held turn, queue and
// output valid, and loads the register defaults (deadzone 5, gain 9830).
// Configuration writes take effect at the next edge.
// ------------------------------------------------------------------------
module joystick_packet_deframer_filter_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [jpdf_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [jpdf_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [jpdf_pkg::BYTE_W-1:0]             rx_byte_i,
  input  logic                                    packet_start_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    accepted_o,
  output logic signed [jpdf_pkg::TS_W-1:0]        speed_cmd_o,
  output logic signed [jpdf_pkg::TURN_W-1:0]      turn_command_o
);

  logic [jpdf_pkg::DZ_W-1:0]   deadzone_q, deadzone_d;
  logic [jpdf_pkg::GAIN_W-1:0] gain_q, gain_d;

  logic           full, empty, push, pop, accept;
  jpdf_pkg::job_t push_job, pop_job;

  always_comb begin
    deadzone_d = deadzone_q;
    gain_d     = gain_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        jpdf_pkg::REG_DEADZONE: deadzone_d = cfg_data_i[jpdf_pkg::DZ_W-1:0];
        jpdf_pkg::REG_GAIN:     gain_d     = cfg_data_i[jpdf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= jpdf_pkg::DZ_RESET;
      gain_q     <= jpdf_pkg::GAIN_RESET;
    end else begin
      deadzone_q <= deadzone_d;
      gain_q     <= gain_d;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jpdf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .packet_start_i (packet_start_i),
    .deadzone_i     (deadzone_q),
    .push_o         (push),
    .job_o          (push_job)
  );

  jpdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty),
    .full_o  (full)
  );

  jpdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .job_i          (pop_job),
    .pop_o          (pop),
    .gain_i         (gain_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .speed_cmd_o    (speed_cmd_o),
    .turn_command_o (turn_command_o)
  );

endmodule

@@ rtl/jpdf_front.sv @@
// ------------------------------------------------------------------------
// jpdf_front
// Collects packet bytes, checks framing and checksum, applies the deadzone.
// ------------------------------------------------------------------------
module jpdf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [jpdf_pkg::BYTE_W-1:0]       rx_byte_i,
  input  logic                              packet_start_i,
  input  logic [jpdf_pkg::DZ_W-1:0]         deadzone_i,
  output logic                              push_o,
  output jpdf_pkg::job_t                    job_o
);

  logic [jpdf_pkg::POS_W-1:0]  pos_q, pos_d, pos;
  logic [jpdf_pkg::BYTE_W-1:0] bytes_q [jpdf_pkg::PKT_BYTES];
  logic [jpdf_pkg::BYTE_W-1:0] csum;
  logic                        wr_byte;

  function automatic logic signed [jpdf_pkg::WORD_W-1:0] dead_zone(
    input logic signed [jpdf_pkg::WORD_W-1:0] v,
    input logic [jpdf_pkg::DZ_W-1:0]          dz
  );
    logic signed [jpdf_pkg::WORD_W:0] ext;
    logic [jpdf_pkg::WORD_W:0]        mag;
    ext = (jpdf_pkg::WORD_W+1)'(v);
    mag = ext[jpdf_pkg::WORD_W] ? unsigned'(-ext) : unsigned'(ext);
    dead_zone = (mag < (jpdf_pkg::WORD_W+1)'(dz)) ? '0 : v;
  endfunction

  assign pos     = packet_start_i ? '0 : pos_q;
  assign wr_byte = accept_i && (pos < jpdf_pkg::POS_LAST);
  assign push_o  = accept_i && (pos == jpdf_pkg::POS_LAST);

  always_comb begin
    pos_d = pos_q;
    if (wr_byte) begin
      pos_d = pos + 1'b1;
    end else if (push_o) begin
      pos_d = jpdf_pkg::POS_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jpdf_pkg::PKT_BYTES; i++) begin
      if (wr_byte && pos == jpdf_pkg::POS_W'(i)) begin
        bytes_q[i] <= rx_byte_i;
      end
    end
  end

  assign csum = bytes_q[1] + bytes_q[2] + bytes_q[3] + bytes_q[4];

  always_comb begin
    job_o.ok    = (bytes_q[0] == jpdf_pkg::HEAD_BYTE) &&
                  (rx_byte_i == jpdf_pkg::TAIL_BYTE) && (csum == bytes_q[5]);
    job_o.speed = dead_zone($signed({bytes_q[2], bytes_q[1]}), deadzone_i);
    job_o.turn  = dead_zone($signed({bytes_q[4], bytes_q[3]}), deadzone_i);
  end

endmodule

@@ rtl/jpdf_queue.sv @@
// ------------------------------------------------------------------------
// jpdf_queue
// Short job queue between the packet checker and the filter sequencer.
// ------------------------------------------------------------------------
`include "joystick_packet_deframer_filter_unit_macros.svh"

module jpdf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jpdf_pkg::job_t job_i,
  input  logic           pop_i,
  output jpdf_pkg::job_t job_o,
  output logic           empty_o,
  output logic           full_o
);

  jpdf_pkg::job_t                 mem_q [jpdf_pkg::QUEUE_DEPTH];
  logic [jpdf_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [jpdf_pkg::QUEUE_CW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == jpdf_pkg::QUEUE_CW'(jpdf_pkg::QUEUE_DEPTH));
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `JPDF_ASSERT_IMPLIES(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `JPDF_ASSERT_IMPLIES(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

@@ rtl/jpdf_back.sv @@
// ------------------------------------------------------------------------
// jpdf_back
// Filter sequencer: multiply, accumulate, then load the output register.
// ------------------------------------------------------------------------
`include "joystick_packet_deframer_filter_unit_macros.svh"

module jpdf_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  jpdf_pkg::job_t                      job_i,
  output logic                                pop_o,
  input  logic [jpdf_pkg::GAIN_W-1:0]         gain_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic signed [jpdf_pkg::TS_W-1:0]    speed_cmd_o,
  output logic signed [jpdf_pkg::TURN_W-1:0]  turn_command_o
);

  jpdf_pkg::back_state_e state_q, state_d;

  jpdf_pkg::job_t                          job_q;
  logic signed [jpdf_pkg::PROD_W-1:0]      prod_q, prod_d;
  logic signed [jpdf_pkg::FV_W-1:0]        fv_q, fv_d;
  logic signed [jpdf_pkg::TURN_W-1:0]      held_turn_q, held_turn_d;
  logic                                    out_valid_q, out_valid_d;
  logic                                    accepted_q;
  logic signed [jpdf_pkg::TS_W-1:0]        speed_q;
  logic signed [jpdf_pkg::TURN_W-1:0]      turn_q;

  logic                                    load_out;
  logic [jpdf_pkg::GAIN_W-1:0]             gain;
  logic signed [jpdf_pkg::XW-1:0]          x;
  logic signed [jpdf_pkg::DIFF_W-1:0]      diff;
  logic signed [jpdf_pkg::PROD_W-1:0]      step;
  logic signed [jpdf_pkg::FV_W-1:0]        q8;
  logic signed [jpdf_pkg::NEG_W-1:0]       neg;
  logic signed [jpdf_pkg::TS_W-1:0]        speed_sat;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jpdf_pkg::S_IDLE: if (!empty_i) state_d = jpdf_pkg::S_MUL;
      jpdf_pkg::S_MUL:  state_d = jpdf_pkg::S_ACC;
      jpdf_pkg::S_ACC:  state_d = jpdf_pkg::S_OUT;
      jpdf_pkg::S_OUT:  if (load_out) state_d = jpdf_pkg::S_IDLE;
      default:          state_d = jpdf_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o    = (state_q == jpdf_pkg::S_IDLE) && !empty_i;
    load_out = (state_q == jpdf_pkg::S_OUT) && (!out_valid_q || !out_stall_i);
  end

  // datapath
  always_comb begin
    gain   = (gain_i > jpdf_pkg::GAIN_ONE) ? jpdf_pkg::GAIN_ONE : gain_i;
    x      = $signed({job_q.speed, {jpdf_pkg::FILTER_FRAC_BITS{1'b0}}});
    diff   = jpdf_pkg::DIFF_W'(x) - jpdf_pkg::DIFF_W'(fv_q);
    // keep the product signed, a rejected packet adds nothing
    prod_d = '0;
    if (job_q.ok) begin
      prod_d = diff * $signed({1'b0, gain});
    end

    step = prod_q >>> jpdf_pkg::GAIN_FRAC_BITS;
    fv_d = (state_q == jpdf_pkg::S_ACC) ? fv_q + jpdf_pkg::FV_W'(step) : fv_q;

    held_turn_d = held_turn_q;
    if (state_q == jpdf_pkg::S_ACC && job_q.ok) begin
      held_turn_d = -jpdf_pkg::TURN_W'(job_q.turn);
    end

    // floor to q8, negate, clamp
    q8  = fv_q >>> jpdf_pkg::Q8_SH;
    neg = -jpdf_pkg::NEG_W'(q8);
    if (neg > jpdf_pkg::TS_MAX) begin
      speed_sat = jpdf_pkg::TS_W'(jpdf_pkg::TS_MAX);
    end else if (neg < jpdf_pkg::TS_MIN) begin
      speed_sat = jpdf_pkg::TS_W'(jpdf_pkg::TS_MIN);
    end else begin
      speed_sat = neg[jpdf_pkg::TS_W-1:0];
    end

    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jpdf_pkg::S_IDLE;
      fv_q        <= '0;
      held_turn_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fv_q        <= fv_d;
      held_turn_q <= held_turn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == jpdf_pkg::S_MUL) begin
      prod_q <= prod_d;
    end
    if (load_out) begin
      accepted_q <= job_q.ok;
      speed_q    <= speed_sat;
      turn_q     <= held_turn_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign speed_cmd_o    = speed_q;
  assign turn_command_o = turn_q;

  `JPDF_ASSERT_NEXT(a_mul_then_acc, clk_i, rst_ni, state_q == jpdf_pkg::S_MUL, state_q == jpdf_pkg::S_ACC)
  `JPDF_ASSERT_NEXT(a_reject_keeps_filter, clk_i, rst_ni, state_q == jpdf_pkg::S_ACC && !job_q.ok, $stable(fv_q) && $stable(held_turn_q))

endmodule
